/* rtl/evest_pkg.sv */
// Shared types and constants of the encoder velocity estimator.
package evest_pkg;

  // Counts per second scale applied to a count difference
  localparam int unsigned US_PER_S = 1000000;
  // Unity weight of the exponential average
  localparam int unsigned EMA_ONE = 256;
  // Bits of a count difference times one million, signed
  localparam int unsigned VPROD_W = 37;

  // Filter modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_EMA  = 2'd1;
  localparam logic [1:0] MODE_SMA  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_SETTING = 1'b1;

  // Input item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HRD  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_FILT = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_MDIV = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_VDIV = 8'b1000_0000
  } state_t;

endpackage

/* rtl/evest_ram.sv */
// Generic simple dual-port RAM with registered read.
module evest_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/evest_div.sv */
// Iterative restoring divider, one quotient bit per cycle, unsigned.
module evest_div #(
  parameter int DW = 38
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [DW-1:0] quo
);

  logic [DW-1:0]          num_r;
  logic [31:0]            den_r;
  logic [31:0]            rem;
  logic [$clog2(DW+1)-1:0] cnt;
  logic                   busy;
  logic [32:0]            trial;
  logic                   qbit;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, num_r[DW-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_r <= num;
        den_r <= den;
        rem   <= '0;
        cnt   <= ($clog2(DW+1))'(DW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        num_r <= {num_r[DW-2:0], qbit};
        cnt   <= cnt - 1'b1;
        if (cnt == ($clog2(DW+1))'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = num_r;

endmodule

/* rtl/encoder_velocity_estimator.sv */
// Top level: position tracking, velocity division and filter sequencer.
//
//  channel  | handshake           | beat
//  ---------+---------------------+-------------------------------
//  in       | in_valid / in_stall | op, raw_count, time_us
//  out      | out_valid/out_stall | position, velocity
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. A sample passes the history read, the velocity division
// (skipped when not needed), the filter step, for the moving average a summing
// pass over the average memory at one read per cycle and the mean division,
// and the output state. A clear item goes straight to the output state. A
// waiting result holds the block in its output state until taken. Register
// writes are taken only when idle with no input pending. Synchronous reset
// clears control state; no clearing pass.
module encoder_velocity_estimator #(
  parameter int HISTORY_DEPTH = 5,
  parameter int AVERAGE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [15:0]        raw_count,
  input  logic [31:0]        time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] position,
  output logic signed [31:0] velocity,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int HA = $clog2(HISTORY_DEPTH);
  localparam int HF = $clog2(HISTORY_DEPTH + 1);
  localparam int AA = $clog2(AVERAGE_DEPTH);
  localparam int AF = $clog2(AVERAGE_DEPTH + 1);
  localparam int SUM_W = 32 + AF;
  localparam int DIV_W = (SUM_W > 36) ? SUM_W : 36;
  localparam int VP = evest_pkg::VPROD_W;

  evest_pkg::state_t state;

  // Architectural registers
  logic [1:0]         filter_mode;
  logic [7:0]         filter_setting;
  logic signed [63:0] position_sum;
  logic [15:0]        previous_raw;
  logic [HA-1:0]      hist_head;
  logic [HF-1:0]      hist_fill;
  logic signed [31:0] filtered;
  logic [AA-1:0]      avg_head;
  logic [AF-1:0]      avg_fill;

  // Work registers
  logic [15:0]          raw_r;
  logic [31:0]          time_r;
  logic signed [31:0]   vraw;
  logic                 neg;
  logic signed [SUM_W-1:0] sum;
  logic [AF-1:0]        ridx;
  logic                 rpend;

  // Memory and divider hookups
  logic          hist_we;
  logic [HA-1:0] hist_raddr;
  logic [47:0]   hist_rdata;
  logic          avg_we;
  logic [AA-1:0] avg_waddr;
  logic [AA-1:0] avg_raddr;
  logic [31:0]   avg_rdata;
  logic          div_start;
  logic [DIV_W-1:0] div_num;
  logic [31:0]   div_den;
  logic          div_done;
  logic [DIV_W-1:0] div_quo;

  logic          accept;
  logic [HA-1:0] hh_eff;
  logic [HA-1:0] hh_next;
  logic [HF-1:0] hf_next;
  logic signed [15:0] pos_delta;
  logic signed [15:0] cnt_delta;
  logic [31:0]   dt;
  logic signed [VP-1:0] vprod;
  logic [VP-1:0] vmag;
  logic [AF-1:0] win;
  logic [AA-1:0] ah_eff;
  logic [AA-1:0] ah_next;
  logic signed [32:0] ema_diff;
  logic signed [42:0] ema_prod;
  logic signed [42:0] ema_adj;
  logic signed [42:0] ema_d;
  logic [8:0]    ema_w;
  logic [SUM_W-1:0] sum_mag;
  logic out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != evest_pkg::S_IDLE);
  assign cfg_ready = (state == evest_pkg::S_IDLE) && !in_valid;
  assign out_free  = !out_valid || !out_stall;

  // History slot bookkeeping for an incoming sample
  always_comb begin
    hh_eff  = (32'(hist_head) >= 32'(HISTORY_DEPTH)) ? '0 : hist_head;
    hh_next = (32'(hh_eff) + 1 == 32'(HISTORY_DEPTH)) ? '0 : HA'(32'(hh_eff) + 1);
    hf_next = (32'(hist_fill) < 32'(HISTORY_DEPTH)) ? HF'(32'(hist_fill) + 1) : hist_fill;
    pos_delta  = signed'(raw_count - previous_raw);
    hist_we    = accept && (op == evest_pkg::OP_SAMPLE);
    hist_raddr = (32'(hf_next) < 32'(HISTORY_DEPTH)) ? '0 : hh_next;
  end

  // Count difference to the oldest entry, scaled to counts per second
  always_comb begin
    cnt_delta = signed'(raw_r - hist_rdata[47:32]);
    dt        = time_r - hist_rdata[31:0];
    vprod     = VP'(cnt_delta) * VP'(evest_pkg::US_PER_S);
    vmag      = vprod[VP-1] ? VP'(-vprod) : VP'(vprod);
  end

  // Moving-average window and write slot
  always_comb begin
    if (filter_setting < 8'd2) begin
      win = AF'(2);
    end else if (32'(filter_setting) > 32'(AVERAGE_DEPTH)) begin
      win = AF'(AVERAGE_DEPTH);
    end else begin
      win = AF'(filter_setting);
    end
    ah_eff  = (32'(avg_head) >= 32'(win)) ? '0 : avg_head;
    ah_next = (32'(ah_eff) + 1 == 32'(win)) ? '0 : AA'(32'(ah_eff) + 1);
    avg_we    = (state == evest_pkg::S_FILT) && (filter_mode == evest_pkg::MODE_SMA);
    avg_waddr = ah_eff;
    avg_raddr = AA'(ridx);
  end

  // Exponential average step, truncated toward zero
  always_comb begin
    ema_w    = 9'(evest_pkg::EMA_ONE) - 9'(filter_setting);
    ema_diff = 33'(vraw) - 33'(filtered);
    ema_prod = 43'(ema_diff) * 43'(signed'({1'b0, ema_w}));
    ema_adj  = ema_prod + (ema_prod[42] ? 43'sd255 : 43'sd0);
    ema_d    = ema_adj >>> 8;
    sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  end

  // Divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_W'(vmag);
    div_den   = dt;
    if (state == evest_pkg::S_HRD) begin
      div_start = (32'(hist_fill) >= 2) && (dt != 32'd0);
    end else if (state == evest_pkg::S_SUM) begin
      div_start = (ridx == avg_fill) && !rpend;
      div_num   = DIV_W'(sum_mag);
      div_den   = 32'(avg_fill);
    end
  end

  // Sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= evest_pkg::S_IDLE;
      filter_mode    <= evest_pkg::MODE_NONE;
      filter_setting <= '0;
      position_sum   <= '0;
      previous_raw   <= '0;
      hist_head      <= '0;
      hist_fill      <= '0;
      filtered       <= '0;
      avg_head       <= '0;
      avg_fill       <= '0;
      out_valid      <= 1'b0;
      rpend          <= 1'b0;
      ridx           <= '0;
    end else begin
      // Result taken; the output state refills it itself
      if (out_valid && !out_stall && (state != evest_pkg::S_OUT)) begin
        out_valid <= 1'b0;
      end

      // Register writes clear the filter
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == evest_pkg::CFG_MODE) begin
          filter_mode <= (cfg_data[1:0] == 2'd3) ? evest_pkg::MODE_NONE : cfg_data[1:0];
        end else begin
          filter_setting <= cfg_data;
        end
        filtered <= '0;
        avg_head <= '0;
        avg_fill <= '0;
      end

      case (state)
        evest_pkg::S_IDLE: begin
          if (accept) begin
            if (op == evest_pkg::OP_CLEAR) begin
              position_sum <= '0;
              previous_raw <= '0;
              hist_head    <= '0;
              hist_fill    <= '0;
              filtered     <= '0;
              avg_head     <= '0;
              avg_fill     <= '0;
              state        <= evest_pkg::S_OUT;
            end else begin
              position_sum <= position_sum + 64'(pos_delta);
              previous_raw <= raw_count;
              hist_head    <= hh_next;
              hist_fill    <= hf_next;
              raw_r        <= raw_count;
              time_r       <= time_us;
              state        <= evest_pkg::S_HRD;
            end
          end
        end
        evest_pkg::S_HRD: begin
          neg <= vprod[VP-1];
          if (div_start) begin
            state <= evest_pkg::S_VDIV;
          end else begin
            vraw  <= '0;
            state <= evest_pkg::S_FILT;
          end
        end
        evest_pkg::S_VDIV: begin
          state <= evest_pkg::S_DIV;
        end
        evest_pkg::S_DIV: begin
          if (div_done) begin
            // Saturate to the signed 32-bit range
            if (!neg) begin
              vraw <= (div_quo > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : signed'(div_quo[31:0]);
            end else begin
              vraw <= (div_quo >= DIV_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                          : signed'(-div_quo[31:0]);
            end
            state <= evest_pkg::S_FILT;
          end
        end
        evest_pkg::S_FILT: begin
          case (filter_mode)
            evest_pkg::MODE_EMA: begin
              filtered <= (filter_setting == 8'd0) ? vraw : filtered + ema_d[31:0];
              state    <= evest_pkg::S_OUT;
            end
            evest_pkg::MODE_SMA: begin
              avg_head <= ah_next;
              if (avg_fill < win) begin
                avg_fill <= avg_fill + 1'b1;
              end
              sum   <= '0;
              ridx  <= '0;
              rpend <= 1'b0;
              state <= evest_pkg::S_SUM;
            end
            default: begin
              filtered <= vraw;
              state    <= evest_pkg::S_OUT;
            end
          endcase
        end
        evest_pkg::S_SUM: begin
          // One read a cycle, accumulate in the cycle after the read
          if (ridx != avg_fill) begin
            ridx  <= ridx + 1'b1;
            rpend <= 1'b1;
          end else begin
            rpend <= 1'b0;
          end
          if (rpend) begin
            sum <= sum + SUM_W'(signed'(avg_rdata));
          end
          if (div_start) begin
            neg   <= sum[SUM_W-1];
            state <= evest_pkg::S_MDIV;
          end
        end
        evest_pkg::S_MDIV: begin
          if (div_done) begin
            filtered <= neg ? signed'(-div_quo[31:0]) : signed'(div_quo[31:0]);
            state    <= evest_pkg::S_OUT;
          end
        end
        evest_pkg::S_OUT: begin
          if (out_free) begin
            position  <= position_sum;
            velocity  <= filtered;
            out_valid <= 1'b1;
            state     <= evest_pkg::S_IDLE;
          end
        end
        default: begin
          state <= evest_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Count and time history
  evest_ram #(.WIDTH(48), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hh_eff),
    .wdata ({raw_count, time_us}),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Moving-average samples
  evest_ram #(.WIDTH(32), .DEPTH(AVERAGE_DEPTH)) u_avg (
    .clk   (clk),
    .we    (avg_we),
    .waddr (avg_waddr),
    .wdata (vraw),
    .raddr (avg_raddr),
    .rdata (avg_rdata)
  );

  // Shared divider for velocity and mean
  evest_div #(.DW(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

/* rtl/evest_checker.sv */
// Port-level checks of the encoder velocity estimator, bound to the top level.
module evest_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] position,
  input logic signed [31:0] velocity
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(velocity))
    else $error("stalled result changed");

  // One item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // Reset leaves no result pending
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind encoder_velocity_estimator evest_checker u_evest_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .position  (position),
  .velocity  (velocity)
);
